[design/cts_pkg.sv]
// shared types, codes and the control store for the coin timed session controller
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps

package cts_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_BAHT_PER_MINUTE   = 3'd0;
  localparam logic [2:0] CFG_MULTI_BILL        = 3'd1;
  localparam logic [2:0] CFG_MAX_CREDIT        = 3'd2;
  localparam logic [2:0] CFG_START_COUNTDOWN   = 3'd3;
  localparam logic [2:0] CFG_MACHINE_START_SEC = 3'd4;
  localparam logic [2:0] CFG_MACHINE_THRESHOLD = 3'd5;
  localparam logic [2:0] CFG_MACHINE_ADD_SEC   = 3'd6;
  localparam logic [2:0] CFG_MASSAGE_MODE      = 3'd7;

  // configuration reset values
  localparam logic [7:0]  RST_BAHT_PER_MINUTE   = 8'd2;
  localparam logic        RST_MULTI_BILL        = 1'b1;
  localparam logic [15:0] RST_MAX_CREDIT        = 16'd120;
  localparam logic [7:0]  RST_START_COUNTDOWN   = 8'd10;
  localparam logic [15:0] RST_MACHINE_START_SEC = 16'd2400;
  localparam logic [15:0] RST_MACHINE_THRESHOLD = 16'd1800;
  localparam logic [15:0] RST_MACHINE_ADD_SEC   = 16'd600;
  localparam logic [3:0]  RST_MASSAGE_MODE      = 4'd2;

  // saturation limits
  localparam logic [17:0] SESSION_MAX = 18'h3FFFF;
  localparam logic [15:0] WORD16_MAX  = 16'hFFFF;

  // input command codes
  localparam logic CMD_BILL = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // phase codes as seen on the result item
  localparam logic [1:0] PH_CODE_RESET = 2'd0;
  localparam logic [1:0] PH_CODE_IDLE  = 2'd1;
  localparam logic [1:0] PH_CODE_START = 2'd2;
  localparam logic [1:0] PH_CODE_RUN   = 2'd3;

  // remote action codes
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_HARD_RESET = 3'd1;
  localparam logic [2:0] ACT_START      = 3'd2;
  localparam logic [2:0] ACT_ADD        = 3'd3;
  localparam logic [2:0] ACT_END        = 3'd4;

  typedef enum logic [3:0] {
    PH_RESET = 4'b0001,
    PH_IDLE  = 4'b0010,
    PH_START = 4'b0100,
    PH_RUN   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       command;
    logic [9:0] bill_amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  remote_action;
    logic [3:0]  remote_mode;
    logic        inhibit;
    logic [17:0] session_seconds;
    logic [7:0]  start_seconds;
    logic [15:0] credit_total;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CREDIT,
    OP_DIV_START,
    OP_SECS,
    OP_CLEAR_HR,
    OP_START_DEC,
    OP_GO,
    OP_SESS_DEC,
    OP_MACH_DEC,
    OP_ADD_TIME,
    OP_CLEAR_END
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_TICK,
    C_INHIBIT,
    C_DIV_BUSY,
    C_PH_RESET,
    C_PH_START,
    C_PH_RUN,
    C_START_ZERO,
    C_SESS_ZERO,
    C_MACH_LIVE,
    C_EXTEND
  } cond_e;

  localparam int unsigned PC_W = 5;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic            inv;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  // program entry points
  localparam logic [PC_W-1:0] A_ENTRY     = 5'd0;
  localparam logic [PC_W-1:0] A_DIV_WAIT  = 5'd4;
  localparam logic [PC_W-1:0] A_TICK      = 5'd6;
  localparam logic [PC_W-1:0] A_HARD      = 5'd10;
  localparam logic [PC_W-1:0] A_START     = 5'd11;
  localparam logic [PC_W-1:0] A_RUN       = 5'd14;
  localparam logic [PC_W-1:0] A_END       = 5'd20;
  localparam logic [PC_W-1:0] A_DONE      = 5'd21;

  function automatic uword_t mk(op_e op, cond_e cond, logic inv,
                                logic [PC_W-1:0] target, logic last);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.inv    = inv;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // control store
  function automatic uword_t rom_word(logic [PC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      // dispatch on command, bill path
      5'd0:  w = mk(OP_NOP,       C_TICK,       1'b0, A_TICK,     1'b0);
      5'd1:  w = mk(OP_NOP,       C_INHIBIT,    1'b0, A_DONE,     1'b0);
      5'd2:  w = mk(OP_CREDIT,    C_NEVER,      1'b0, A_DONE,     1'b0);
      5'd3:  w = mk(OP_DIV_START, C_NEVER,      1'b0, A_DONE,     1'b0);
      5'd4:  w = mk(OP_NOP,       C_DIV_BUSY,   1'b0, A_DIV_WAIT, 1'b0);
      5'd5:  w = mk(OP_SECS,      C_ALWAYS,     1'b0, A_DONE,     1'b0);
      // tick dispatch on phase
      5'd6:  w = mk(OP_NOP,       C_PH_RESET,   1'b0, A_HARD,     1'b0);
      5'd7:  w = mk(OP_NOP,       C_PH_START,   1'b0, A_START,    1'b0);
      5'd8:  w = mk(OP_NOP,       C_PH_RUN,     1'b0, A_RUN,      1'b0);
      5'd9:  w = mk(OP_NOP,       C_ALWAYS,     1'b0, A_DONE,     1'b0);
      5'd10: w = mk(OP_CLEAR_HR,  C_ALWAYS,     1'b0, A_DONE,     1'b0);
      // start countdown
      5'd11: w = mk(OP_START_DEC, C_NEVER,      1'b0, A_DONE,     1'b0);
      5'd12: w = mk(OP_NOP,       C_START_ZERO, 1'b1, A_DONE,     1'b0);
      5'd13: w = mk(OP_GO,        C_ALWAYS,     1'b0, A_DONE,     1'b0);
      // running
      5'd14: w = mk(OP_SESS_DEC,  C_NEVER,      1'b0, A_DONE,     1'b0);
      5'd15: w = mk(OP_NOP,       C_SESS_ZERO,  1'b0, A_END,      1'b0);
      5'd16: w = mk(OP_NOP,       C_MACH_LIVE,  1'b1, A_DONE,     1'b0);
      5'd17: w = mk(OP_MACH_DEC,  C_NEVER,      1'b0, A_DONE,     1'b0);
      5'd18: w = mk(OP_NOP,       C_EXTEND,     1'b1, A_DONE,     1'b0);
      5'd19: w = mk(OP_ADD_TIME,  C_ALWAYS,     1'b0, A_DONE,     1'b0);
      5'd20: w = mk(OP_CLEAR_END, C_ALWAYS,     1'b0, A_DONE,     1'b0);
      default: w = mk(OP_NOP,     C_NEVER,      1'b0, A_DONE,     1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] c;
    unique case (ph)
      PH_RESET: c = PH_CODE_RESET;
      PH_IDLE:  c = PH_CODE_IDLE;
      PH_START: c = PH_CODE_START;
      PH_RUN:   c = PH_CODE_RUN;
      default:  c = PH_CODE_RESET;
    endcase
    return c;
  endfunction

endpackage

[design/cts_div.sv]
// serial restoring divider, one quotient bit per cycle
// standalone, no package use
`timescale 1ns / 1ps

module cts_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [9:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       busy_o,
  output logic [9:0] quotient_o
);

  logic [3:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d;
  logic [9:0] quo_q, quo_d;
  logic [7:0] dvs_q, dvs_d;
  logic [8:0] trial;
  logic       fits;

  assign trial = {rem_q, quo_q[9]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = 4'd10;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != 4'd0) begin
      cnt_d = cnt_q - 4'd1;
      // remainder stays below the divisor, so it fits in eight bits
      rem_d = fits ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
      quo_d = {quo_q[8:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = cnt_q != 4'd0;
  assign quotient_o = quo_q;

endmodule

[design/coin_timed_session_controller.sv]
// coin timed session controller top level: microcoded sequencer and datapath
// depends on cts_pkg and cts_div
`timescale 1ns / 1ps
// sequence: an accepted bill is credited, divided by the rate and turned into seconds
//   before the result register loads; a refused bill skips to the final step; ticks branch on the phase
// items: one item at a time; the next item is taken the cycle after the result is
//   loaded, so an accepted bill spends most of its time on the serial divider
// reset: asynchronous, active low; configuration returns to its defaults, the block
//   sits in the reset phase with the acceptor inhibited and no memory to clear

module coin_timed_session_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cts_pkg::in_item_t  in_data_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cts_pkg::out_item_t out_data_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // configuration registers
  logic [7:0]  bpm_q;
  logic        multi_q;
  logic [15:0] max_credit_q;
  logic [7:0]  start_cd_q;
  logic [15:0] mach_start_q;
  logic [15:0] mach_thr_q;
  logic [15:0] mach_add_q;
  logic [3:0]  mode_q;

  // session state
  cts_pkg::phase_e phase_q, phase_d;
  logic [17:0] session_q, session_d;
  logic [7:0]  start_q, start_d;
  logic [15:0] machine_q, machine_d;
  logic        active_q, active_d;
  logic [15:0] credit_q, credit_d;
  logic        inhibit_q, inhibit_d;
  logic [2:0]  action_q, action_d;

  // sequencer
  logic                     busy_q, busy_d;
  logic [cts_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     cmd_q;
  logic [9:0]               amount_q;
  cts_pkg::uword_t          uw;
  logic                     cond_raw;
  logic                     take_jump;
  logic                     in_accept;
  logic                     emit;

  // result register
  logic               out_valid_q, out_valid_d;
  cts_pkg::out_item_t out_q;

  // divider
  logic       div_start;
  logic       div_busy;
  logic [9:0] quotient;
  logic [7:0] divisor;

  // arithmetic
  logic [16:0] credit_sum;
  logic [15:0] credit_sat;
  logic [15:0] secs;
  logic [18:0] session_sum;
  logic [16:0] machine_sum;
  logic [17:0] session_dec;
  logic [15:0] machine_dec;

  // configuration is taken whenever offered; it must only arrive while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpm_q        <= cts_pkg::RST_BAHT_PER_MINUTE;
      multi_q      <= cts_pkg::RST_MULTI_BILL;
      max_credit_q <= cts_pkg::RST_MAX_CREDIT;
      start_cd_q   <= cts_pkg::RST_START_COUNTDOWN;
      mach_start_q <= cts_pkg::RST_MACHINE_START_SEC;
      mach_thr_q   <= cts_pkg::RST_MACHINE_THRESHOLD;
      mach_add_q   <= cts_pkg::RST_MACHINE_ADD_SEC;
      mode_q       <= cts_pkg::RST_MASSAGE_MODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cts_pkg::CFG_BAHT_PER_MINUTE:   bpm_q        <= cfg_data_i[7:0];
        cts_pkg::CFG_MULTI_BILL:        multi_q      <= cfg_data_i[0];
        cts_pkg::CFG_MAX_CREDIT:        max_credit_q <= cfg_data_i;
        cts_pkg::CFG_START_COUNTDOWN:   start_cd_q   <= cfg_data_i[7:0];
        cts_pkg::CFG_MACHINE_START_SEC: mach_start_q <= cfg_data_i;
        cts_pkg::CFG_MACHINE_THRESHOLD: mach_thr_q   <= cfg_data_i;
        cts_pkg::CFG_MACHINE_ADD_SEC:   mach_add_q   <= cfg_data_i;
        cts_pkg::CFG_MASSAGE_MODE:      mode_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // a rate of zero divides as one
  assign divisor = (bpm_q == 8'd0) ? 8'd1 : bpm_q;

  cts_div u_cts_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (amount_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // control word for the current step
  assign uw        = cts_pkg::rom_word(pc_q);
  assign in_stall_o = busy_q;
  assign in_accept = in_valid_i && !busy_q;
  // the final step waits while an earlier result is still held
  assign emit      = busy_q && uw.last && !(out_valid_q && out_stall_i);
  assign div_start = busy_q && (uw.op == cts_pkg::OP_DIV_START);

  always_comb begin
    unique case (uw.cond)
      cts_pkg::C_NEVER:      cond_raw = 1'b0;
      cts_pkg::C_ALWAYS:     cond_raw = 1'b1;
      cts_pkg::C_TICK:       cond_raw = cmd_q == cts_pkg::CMD_TICK;
      cts_pkg::C_INHIBIT:    cond_raw = inhibit_q;
      cts_pkg::C_DIV_BUSY:   cond_raw = div_busy;
      cts_pkg::C_PH_RESET:   cond_raw = phase_q == cts_pkg::PH_RESET;
      cts_pkg::C_PH_START:   cond_raw = phase_q == cts_pkg::PH_START;
      cts_pkg::C_PH_RUN:     cond_raw = phase_q == cts_pkg::PH_RUN;
      cts_pkg::C_START_ZERO: cond_raw = start_q == 8'd0;
      cts_pkg::C_SESS_ZERO:  cond_raw = session_q == 18'd0;
      cts_pkg::C_MACH_LIVE:  cond_raw = active_q && (machine_q != 16'd0);
      // extension: machine time at the threshold and enough session left
      cts_pkg::C_EXTEND:     cond_raw = (machine_q == mach_thr_q) &&
                                        (session_q >= {2'b00, mach_thr_q});
      default:               cond_raw = 1'b0;
    endcase
  end

  assign take_jump = cond_raw ^ uw.inv;

  // step counter
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (in_accept) begin
      busy_d = 1'b1;
      pc_d   = cts_pkg::A_ENTRY;
    end else if (busy_q) begin
      if (uw.last) begin
        if (emit) begin
          busy_d = 1'b0;
          pc_d   = cts_pkg::A_ENTRY;
        end
      end else if (take_jump) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + 5'd1;
      end
    end
  end

  // datapath arithmetic
  assign credit_sum  = {1'b0, credit_q} + {7'd0, amount_q};
  assign credit_sat  = credit_sum[16] ? cts_pkg::WORD16_MAX : credit_sum[15:0];
  // quotient times sixty as two shifts, plus the extra second
  assign secs        = 16'({quotient, 6'd0} - {4'd0, quotient, 2'd0}) + 16'd1;
  assign session_sum = {1'b0, session_q} + {3'd0, secs};
  assign machine_sum = {1'b0, machine_q} + {1'b0, mach_add_q};
  assign session_dec = (session_q != 18'd0) ? session_q - 18'd1 : session_q;
  assign machine_dec = machine_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    session_d = session_q;
    start_d   = start_q;
    machine_d = machine_q;
    active_d  = active_q;
    credit_d  = credit_q;
    inhibit_d = inhibit_q;
    action_d  = action_q;
    if (in_accept) begin
      action_d = cts_pkg::ACT_NONE;
    end else if (busy_q) begin
      unique case (uw.op)
        cts_pkg::OP_NOP, cts_pkg::OP_DIV_START: ;
        cts_pkg::OP_CREDIT: begin
          credit_d = credit_sat;
          if (!multi_q || (credit_sat >= max_credit_q)) begin
            inhibit_d = 1'b1;
          end
          start_d = start_cd_q;
        end
        cts_pkg::OP_SECS: begin
          session_d = (session_sum > {1'b0, cts_pkg::SESSION_MAX}) ?
                      cts_pkg::SESSION_MAX : session_sum[17:0];
          if (phase_q == cts_pkg::PH_IDLE) begin
            phase_d = cts_pkg::PH_START;
          end
        end
        cts_pkg::OP_CLEAR_HR, cts_pkg::OP_CLEAR_END: begin
          session_d = '0;
          start_d   = '0;
          machine_d = '0;
          active_d  = 1'b0;
          credit_d  = '0;
          inhibit_d = 1'b0;
          phase_d   = cts_pkg::PH_IDLE;
          action_d  = (uw.op == cts_pkg::OP_CLEAR_HR) ? cts_pkg::ACT_HARD_RESET :
                                                      cts_pkg::ACT_END;
        end
        cts_pkg::OP_START_DEC: begin
          if (start_q != 8'd0) begin
            start_d = start_q - 8'd1;
          end
        end
        cts_pkg::OP_GO: begin
          inhibit_d = 1'b1;
          machine_d = mach_start_q;
          active_d  = 1'b1;
          phase_d   = cts_pkg::PH_RUN;
          action_d  = cts_pkg::ACT_START;
        end
        cts_pkg::OP_SESS_DEC: session_d = session_dec;
        cts_pkg::OP_MACH_DEC: machine_d = machine_dec;
        cts_pkg::OP_ADD_TIME: begin
          machine_d = machine_sum[16] ? cts_pkg::WORD16_MAX : machine_sum[15:0];
          action_d  = cts_pkg::ACT_ADD;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cts_pkg::PH_RESET;
      session_q <= '0;
      start_q   <= '0;
      machine_q <= '0;
      active_q  <= 1'b0;
      credit_q  <= '0;
      inhibit_q <= 1'b1;
      action_q  <= cts_pkg::ACT_NONE;
      busy_q    <= 1'b0;
      pc_q      <= cts_pkg::A_ENTRY;
    end else begin
      phase_q   <= phase_d;
      session_q <= session_d;
      start_q   <= start_d;
      machine_q <= machine_d;
      active_q  <= active_d;
      credit_q  <= credit_d;
      inhibit_q <= inhibit_d;
      action_q  <= action_d;
      busy_q    <= busy_d;
      pc_q      <= pc_d;
    end
  end

  // captured item fields
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= in_data_i.command;
      amount_q <= in_data_i.bill_amount;
    end
  end

  // result register, loaded by the final step of the program
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.phase           <= cts_pkg::phase_code(phase_q);
      out_q.remote_action   <= action_q;
      out_q.remote_mode     <= (action_q == cts_pkg::ACT_START) ? mode_q : 4'd0;
      out_q.inhibit         <= inhibit_q;
      out_q.session_seconds <= session_q;
      out_q.start_seconds   <= start_q;
      out_q.credit_total    <= credit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/cts_checker.sv]
// port level checks for the coin timed session controller, bound to the top level
// depends on cts_pkg and coin_timed_session_controller
`timescale 1ns / 1ps

module cts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input cts_pkg::out_item_t out_data_i
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result item changed");

  // program number only travels with a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.remote_action != cts_pkg::ACT_START)
      |-> out_data_i.remote_mode == 4'd0)
    else $error("remote mode without start");

  // hard reset and end both leave a cleared idle session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_data_i.remote_action == cts_pkg::ACT_HARD_RESET) ||
                    (out_data_i.remote_action == cts_pkg::ACT_END))
      |-> (out_data_i.phase == cts_pkg::PH_CODE_IDLE) && !out_data_i.inhibit &&
          (out_data_i.session_seconds == 18'd0) && (out_data_i.credit_total == 16'd0))
    else $error("session not cleared");

  // start enters the running phase with the acceptor inhibited and the countdown at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.remote_action == cts_pkg::ACT_START)
      |-> (out_data_i.phase == cts_pkg::PH_CODE_RUN) && out_data_i.inhibit &&
          (out_data_i.start_seconds == 8'd0))
    else $error("start without running phase");

  // the reset phase only ever reports an inhibited, empty session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.phase == cts_pkg::PH_CODE_RESET)
      |-> out_data_i.inhibit && (out_data_i.remote_action == cts_pkg::ACT_NONE) &&
          (out_data_i.credit_total == 16'd0))
    else $error("reset phase result not empty");

endmodule

bind coin_timed_session_controller cts_checker u_cts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
